// ===== rtl/sst_pkg.sv =====
package sst_pkg;

    localparam int SST_QUEUE_DEPTH = 16;
    localparam int SST_SECTOR_BITS = 48;
    localparam int SST_PORT_SECTOR_BITS = 48;
    localparam int SST_TAG_BITS = 8;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_IGNORED  = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_NO_TAG = 2'd3
    } t_status;

    // update broadcast to every cell of the row
    typedef struct packed {
        logic add;
        logic del;
    } t_cell_cmd;

    // control part of the search token that walks along the row
    typedef struct packed {
        logic go;
        logic dispatch;
        logic found;
    } t_scan_ctl;

endpackage

// ===== rtl/shortest_seek_first_scheduler_unit.sv =====
// channel   direction  handshake             payload
// request   in         i_valid / o_stall     i_command, i_new_sector, i_request_tag
// response  out        o_valid / i_stall     o_status, o_served_sector, o_served_tag
//
// add and ignored: the response is registered from S_FINISH once the output is free
// dispatch and remove: a search token, seeded from a register, walks the row of cells
// one cell per cycle to the tail, then the chosen entry is removed by shifting the
// younger cells down all at once, and the response is registered from S_FINISH
// one transaction is in flight at a time; o_stall is high until the response is
// registered, and a stalled response waits in the output register
// reset is synchronous and clears the table, the last sector and the output valid
module shortest_seek_first_scheduler_unit import sst_pkg::*; #(
    parameter int QUEUE_DEPTH = SST_QUEUE_DEPTH,
    parameter int SECTOR_BITS = SST_SECTOR_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_command,
    input  logic [SST_PORT_SECTOR_BITS-1:0] i_new_sector,
    input  logic [SST_TAG_BITS-1:0]         i_request_tag,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_status,
    output logic [SST_PORT_SECTOR_BITS-1:0] o_served_sector,
    output logic [SST_TAG_BITS-1:0]         o_served_tag
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int SW = SECTOR_BITS;

    t_cell_cmd               cmd;
    logic [IW-1:0]           del_idx;
    logic [SW-1:0]           add_sector;
    logic [SST_TAG_BITS-1:0] add_tag;
    logic [SW-1:0]           last_sector;
    logic                    last_known;
    logic [SST_TAG_BITS-1:0] match_tag;
    t_scan_ctl               seed_ctl;

    logic                    used   [QUEUE_DEPTH];
    logic [SW-1:0]           sector [QUEUE_DEPTH];
    logic [SST_TAG_BITS-1:0] tag    [QUEUE_DEPTH];

    // token links: link k feeds cell k, link QUEUE_DEPTH is the tail
    t_scan_ctl               scan_ctl    [QUEUE_DEPTH+1];
    logic [SW-1:0]           scan_dist   [QUEUE_DEPTH+1];
    logic [IW-1:0]           scan_idx    [QUEUE_DEPTH+1];
    logic [SW-1:0]           scan_sector [QUEUE_DEPTH+1];
    logic [SST_TAG_BITS-1:0] scan_tag    [QUEUE_DEPTH+1];

    assign scan_ctl[0]    = seed_ctl;
    assign scan_dist[0]   = '0;
    assign scan_idx[0]    = '0;
    assign scan_sector[0] = '0;
    assign scan_tag[0]    = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                    prev_used;
        logic                    next_used;
        logic [SW-1:0]           next_sector;
        logic [SST_TAG_BITS-1:0] next_tag;

        if (g == 0) begin : g_head
            assign prev_used = 1'b1;
        end else begin : g_body
            assign prev_used = used[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next_used   = 1'b0;
            assign next_sector = sector[g];
            assign next_tag    = tag[g];
        end else begin : g_inner
            assign next_used   = used[g+1];
            assign next_sector = sector[g+1];
            assign next_tag    = tag[g+1];
        end

        sst_cell #(
            .SW  (SW),
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_del_idx     (del_idx),
            .i_add_sector  (add_sector),
            .i_add_tag     (add_tag),
            .i_prev_used   (prev_used),
            .i_next_used   (next_used),
            .i_next_sector (next_sector),
            .i_next_tag    (next_tag),
            .i_last_sector (last_sector),
            .i_last_known  (last_known),
            .i_match_tag   (match_tag),
            .i_scan_ctl    (scan_ctl[g]),
            .i_scan_dist   (scan_dist[g]),
            .i_scan_idx    (scan_idx[g]),
            .i_scan_sector (scan_sector[g]),
            .i_scan_tag    (scan_tag[g]),
            .o_used        (used[g]),
            .o_sector      (sector[g]),
            .o_tag         (tag[g]),
            .o_scan_ctl    (scan_ctl[g+1]),
            .o_scan_dist   (scan_dist[g+1]),
            .o_scan_idx    (scan_idx[g+1]),
            .o_scan_sector (scan_sector[g+1]),
            .o_scan_tag    (scan_tag[g+1])
        );
    end

    sst_ctrl #(
        .SW (SW),
        .IW (IW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_new_sector    (i_new_sector),
        .i_request_tag   (i_request_tag),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_served_sector (o_served_sector),
        .o_served_tag    (o_served_tag),
        .i_full          (used[QUEUE_DEPTH-1]),
        .i_tail_ctl      (scan_ctl[QUEUE_DEPTH]),
        .i_tail_idx      (scan_idx[QUEUE_DEPTH]),
        .i_tail_sector   (scan_sector[QUEUE_DEPTH]),
        .i_tail_tag      (scan_tag[QUEUE_DEPTH]),
        .o_cmd           (cmd),
        .o_del_idx       (del_idx),
        .o_add_sector    (add_sector),
        .o_add_tag       (add_tag),
        .o_last_sector   (last_sector),
        .o_last_known    (last_known),
        .o_match_tag     (match_tag),
        .o_seed_ctl      (seed_ctl)
    );

endmodule

// ===== rtl/sst_cell.sv =====
module sst_cell import sst_pkg::*; #(
    parameter int SW  = SST_SECTOR_BITS,
    parameter int IW  = 4,
    parameter int IDX = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_cmd               i_cmd,
    input  logic [IW-1:0]           i_del_idx,
    input  logic [SW-1:0]           i_add_sector,
    input  logic [SST_TAG_BITS-1:0] i_add_tag,
    input  logic                    i_prev_used,
    input  logic                    i_next_used,
    input  logic [SW-1:0]           i_next_sector,
    input  logic [SST_TAG_BITS-1:0] i_next_tag,
    input  logic [SW-1:0]           i_last_sector,
    input  logic                    i_last_known,
    input  logic [SST_TAG_BITS-1:0] i_match_tag,
    input  t_scan_ctl               i_scan_ctl,
    input  logic [SW-1:0]           i_scan_dist,
    input  logic [IW-1:0]           i_scan_idx,
    input  logic [SW-1:0]           i_scan_sector,
    input  logic [SST_TAG_BITS-1:0] i_scan_tag,
    output logic                    o_used,
    output logic [SW-1:0]           o_sector,
    output logic [SST_TAG_BITS-1:0] o_tag,
    output t_scan_ctl               o_scan_ctl,
    output logic [SW-1:0]           o_scan_dist,
    output logic [IW-1:0]           o_scan_idx,
    output logic [SW-1:0]           o_scan_sector,
    output logic [SST_TAG_BITS-1:0] o_scan_tag
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic                    r_used;
    logic [SW-1:0]           r_sector;
    logic [SST_TAG_BITS-1:0] r_tag;
    t_scan_ctl               r_scan_ctl;
    logic [SW-1:0]           r_scan_dist;
    logic [IW-1:0]           r_scan_idx;
    logic [SW-1:0]           r_scan_sector;
    logic [SST_TAG_BITS-1:0] r_scan_tag;

    logic [SW-1:0] n_dist;
    logic          n_take;
    logic          n_load;
    logic          n_shift;

    always_comb begin
        n_dist = (r_sector >= i_last_sector) ? (r_sector - i_last_sector)
                                             : (i_last_sector - r_sector);
        if (i_scan_ctl.dispatch) begin
            // strict compare keeps the oldest entry on a tie
            n_take = !i_scan_ctl.found || (i_last_known && (n_dist < i_scan_dist));
        end else begin
            n_take = !i_scan_ctl.found && (r_tag == i_match_tag);
        end
        n_take  = n_take && i_scan_ctl.go && r_used;
        n_load  = i_cmd.add && !r_used && i_prev_used;
        n_shift = i_cmd.del && (MY_IDX >= i_del_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= 1'b0;
            r_scan_ctl <= '0;
        end else begin
            if (n_load) begin
                r_used   <= 1'b1;
                r_sector <= i_add_sector;
                r_tag    <= i_add_tag;
            end else if (n_shift) begin
                r_used   <= i_next_used;
                r_sector <= i_next_sector;
                r_tag    <= i_next_tag;
            end
            r_scan_ctl.go       <= i_scan_ctl.go;
            r_scan_ctl.dispatch <= i_scan_ctl.dispatch;
            r_scan_ctl.found    <= i_scan_ctl.found || n_take;
            if (n_take) begin
                r_scan_dist   <= n_dist;
                r_scan_idx    <= MY_IDX;
                r_scan_sector <= r_sector;
                r_scan_tag    <= r_tag;
            end else begin
                r_scan_dist   <= i_scan_dist;
                r_scan_idx    <= i_scan_idx;
                r_scan_sector <= i_scan_sector;
                r_scan_tag    <= i_scan_tag;
            end
        end
    end

    assign o_used        = r_used;
    assign o_sector      = r_sector;
    assign o_tag         = r_tag;
    assign o_scan_ctl    = r_scan_ctl;
    assign o_scan_dist   = r_scan_dist;
    assign o_scan_idx    = r_scan_idx;
    assign o_scan_sector = r_scan_sector;
    assign o_scan_tag    = r_scan_tag;

endmodule

// ===== rtl/sst_ctrl.sv =====
module sst_ctrl import sst_pkg::*; #(
    parameter int SW = SST_SECTOR_BITS,
    parameter int IW = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_command,
    input  logic [SST_PORT_SECTOR_BITS-1:0] i_new_sector,
    input  logic [SST_TAG_BITS-1:0]         i_request_tag,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_status,
    output logic [SST_PORT_SECTOR_BITS-1:0] o_served_sector,
    output logic [SST_TAG_BITS-1:0]         o_served_tag,
    input  logic                            i_full,
    input  t_scan_ctl                       i_tail_ctl,
    input  logic [IW-1:0]                   i_tail_idx,
    input  logic [SW-1:0]                   i_tail_sector,
    input  logic [SST_TAG_BITS-1:0]         i_tail_tag,
    output t_cell_cmd                       o_cmd,
    output logic [IW-1:0]                   o_del_idx,
    output logic [SW-1:0]                   o_add_sector,
    output logic [SST_TAG_BITS-1:0]         o_add_tag,
    output logic [SW-1:0]                   o_last_sector,
    output logic                            o_last_known,
    output logic [SST_TAG_BITS-1:0]         o_match_tag,
    output t_scan_ctl                       o_seed_ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                          r_state;
    logic                            r_seed_go;
    logic                            r_dispatch;
    logic [SW-1:0]                   r_last_sector;
    logic                            r_last_known;
    logic [SST_TAG_BITS-1:0]         r_match_tag;
    t_status                         r_res_status;
    logic [SW-1:0]                   r_res_sector;
    logic [SST_TAG_BITS-1:0]         r_res_tag;
    logic                            r_o_valid;
    t_status                         r_o_status;
    logic [SST_PORT_SECTOR_BITS-1:0] r_o_sector;
    logic [SST_TAG_BITS-1:0]         r_o_tag;

    logic     n_accept;
    t_command n_command;
    logic     n_out_free;
    logic     n_hit;
    logic [63:0] n_res_wide;

    assign n_accept   = i_valid && (r_state == S_IDLE);
    assign n_command  = t_command'(i_command);
    assign n_out_free = !r_o_valid || !i_stall;
    assign n_hit      = (r_state == S_SCAN) && i_tail_ctl.go && i_tail_ctl.found;
    assign n_res_wide = 64'(r_res_sector);

    always_comb begin
        o_cmd.add = n_accept && (n_command == CMD_ADD) && !i_full;
        o_cmd.del = n_hit;
    end

    assign o_del_idx    = i_tail_idx;
    assign o_add_sector = SW'(64'(i_new_sector));
    assign o_add_tag    = i_request_tag;
    assign o_last_sector = r_last_sector;
    assign o_last_known  = r_last_known;
    assign o_match_tag   = r_match_tag;

    always_comb begin
        o_seed_ctl.go       = r_seed_go;
        o_seed_ctl.dispatch = r_dispatch;
        o_seed_ctl.found    = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_seed_go     <= 1'b0;
            r_last_sector <= '0;
            r_last_known  <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_seed_go <= 1'b0;
            // in S_FINISH the response register is reloaded instead
            if (r_o_valid && !i_stall && (r_state != S_FINISH)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_res_sector <= '0;
                        r_res_tag    <= '0;
                        case (n_command)
                            CMD_ADD: begin
                                r_res_status <= i_full ? ST_FULL : ST_DONE;
                                r_state      <= S_FINISH;
                            end
                            CMD_DISPATCH, CMD_REMOVE: begin
                                // token enters cell 0 next cycle, tag is held for the walk
                                r_seed_go   <= 1'b1;
                                r_dispatch  <= (n_command == CMD_DISPATCH);
                                r_match_tag <= i_request_tag;
                                r_state     <= S_SCAN;
                            end
                            default: begin
                                r_res_status <= ST_DONE;
                                r_state      <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (i_tail_ctl.go) begin
                        if (i_tail_ctl.found) begin
                            r_res_status <= ST_DONE;
                            if (r_dispatch) begin
                                r_res_sector  <= i_tail_sector;
                                r_res_tag     <= i_tail_tag;
                                r_last_sector <= i_tail_sector;
                                r_last_known  <= 1'b1;
                            end
                        end else begin
                            r_res_status <= r_dispatch ? ST_EMPTY : ST_NO_TAG;
                        end
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (n_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_res_status;
                        r_o_sector <= n_res_wide[SST_PORT_SECTOR_BITS-1:0];
                        r_o_tag    <= r_res_tag;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_served_sector = r_o_sector;
    assign o_served_tag    = r_o_tag;

endmodule
